/* rtl/pmfd_pkg.sv */
// Shared types and constants for the particulate sensor frame decoder.
`timescale 1ns / 1ps

package pmfd_pkg;

  localparam logic [7:0]  HDR_FIRST  = 8'hAA;
  localparam logic [7:0]  HDR_SECOND = 8'hC0;
  localparam logic [15:0] SAT_LIMIT  = 16'd9999;

  localparam int unsigned VAL_W = 14;
  localparam int unsigned IDX_W = 4;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] CFG_PM10_GOOD_MAX     = 4'd0;
  localparam logic [IDX_W-1:0] CFG_PM10_MODERATE_MAX = 4'd1;
  localparam logic [IDX_W-1:0] CFG_PM10_DEGRADED_MAX = 4'd2;
  localparam logic [IDX_W-1:0] CFG_PM25_GOOD_MAX     = 4'd3;
  localparam logic [IDX_W-1:0] CFG_PM25_MODERATE_MAX = 4'd4;
  localparam logic [IDX_W-1:0] CFG_PM25_DEGRADED_MAX = 4'd5;
  localparam logic [IDX_W-1:0] CFG_PM10_FLOOR        = 4'd6;
  localparam logic [IDX_W-1:0] CFG_PM25_FLOOR        = 4'd7;

  // Reset values of the configuration registers.
  localparam logic [VAL_W-1:0] RST_PM10_GOOD_MAX     = 14'd150;
  localparam logic [VAL_W-1:0] RST_PM10_MODERATE_MAX = 14'd300;
  localparam logic [VAL_W-1:0] RST_PM10_DEGRADED_MAX = 14'd750;
  localparam logic [VAL_W-1:0] RST_PM25_GOOD_MAX     = 14'd99;
  localparam logic [VAL_W-1:0] RST_PM25_MODERATE_MAX = 14'd200;
  localparam logic [VAL_W-1:0] RST_PM25_DEGRADED_MAX = 14'd500;
  localparam logic [VAL_W-1:0] RST_PM10_FLOOR        = 14'd50;
  localparam logic [VAL_W-1:0] RST_PM25_FLOOR        = 14'd30;

  typedef enum logic [3:0] {
    POS_HUNT  = 4'd0,
    POS_HDR2  = 4'd1,
    POS_DATA0 = 4'd2,
    POS_DATA1 = 4'd3,
    POS_DATA2 = 4'd4,
    POS_DATA3 = 4'd5,
    POS_DATA4 = 4'd6,
    POS_DATA5 = 4'd7,
    POS_SUM   = 4'd8,
    POS_TAIL  = 4'd9
  } pos_t;

  typedef enum logic [1:0] {
    LEVEL_GOOD     = 2'd0,
    LEVEL_MODERATE = 2'd1,
    LEVEL_DEGRADED = 2'd2,
    LEVEL_BAD      = 2'd3
  } level_t;

  typedef struct packed {
    logic [VAL_W-1:0] pm10_good_max;
    logic [VAL_W-1:0] pm10_moderate_max;
    logic [VAL_W-1:0] pm10_degraded_max;
    logic [VAL_W-1:0] pm25_good_max;
    logic [VAL_W-1:0] pm25_moderate_max;
    logic [VAL_W-1:0] pm25_degraded_max;
    logic [VAL_W-1:0] pm10_floor;
    logic [VAL_W-1:0] pm25_floor;
  } cfg_t;

  // Raw little-endian payload values of one frame.
  typedef struct packed {
    logic        done;
    logic [15:0] pm25_raw;
    logic [15:0] pm10_raw;
  } frame_t;

  typedef struct packed {
    logic [VAL_W-1:0] pm25_tenths;
    logic [VAL_W-1:0] pm10_tenths;
    level_t           pm25_level;
    level_t           pm10_level;
    logic             pm25_below_floor;
    logic             pm10_below_floor;
  } result_t;

endpackage

/* rtl/pmfd_cfg_regs.sv */
// Configuration register file with write port and reset values.
`timescale 1ns / 1ps

module pmfd_cfg_regs
  import pmfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pm10_good_max     <= RST_PM10_GOOD_MAX;
      cfg.pm10_moderate_max <= RST_PM10_MODERATE_MAX;
      cfg.pm10_degraded_max <= RST_PM10_DEGRADED_MAX;
      cfg.pm25_good_max     <= RST_PM25_GOOD_MAX;
      cfg.pm25_moderate_max <= RST_PM25_MODERATE_MAX;
      cfg.pm25_degraded_max <= RST_PM25_DEGRADED_MAX;
      cfg.pm10_floor        <= RST_PM10_FLOOR;
      cfg.pm25_floor        <= RST_PM25_FLOOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PM10_GOOD_MAX:     cfg.pm10_good_max     <= cfg_data;
        CFG_PM10_MODERATE_MAX: cfg.pm10_moderate_max <= cfg_data;
        CFG_PM10_DEGRADED_MAX: cfg.pm10_degraded_max <= cfg_data;
        CFG_PM25_GOOD_MAX:     cfg.pm25_good_max     <= cfg_data;
        CFG_PM25_MODERATE_MAX: cfg.pm25_moderate_max <= cfg_data;
        CFG_PM25_DEGRADED_MAX: cfg.pm25_degraded_max <= cfg_data;
        CFG_PM10_FLOOR:        cfg.pm10_floor        <= cfg_data;
        CFG_PM25_FLOOR:        cfg.pm25_floor        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/pmfd_frame_parser.sv */
// Byte-by-byte frame parser: header hunt, payload capture and checksum.
`timescale 1ns / 1ps

module pmfd_frame_parser
  import pmfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_take,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  pos_t       pos;
  pos_t       pos_next;
  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic       sum_matched;
  logic       sum_matched_next;
  logic       frame_done;
  logic [7:0] value_bytes [4];

  // Next state.
  always_comb begin
    unique case (pos)
      // A wrong second byte is dropped, not retried as a header.
      POS_HDR2:  pos_next = (rx_byte == HDR_SECOND) ? POS_DATA0 : POS_HUNT;
      POS_DATA0: pos_next = POS_DATA1;
      POS_DATA1: pos_next = POS_DATA2;
      POS_DATA2: pos_next = POS_DATA3;
      POS_DATA3: pos_next = POS_DATA4;
      POS_DATA4: pos_next = POS_DATA5;
      POS_DATA5: pos_next = POS_SUM;
      POS_SUM:   pos_next = POS_TAIL;
      POS_TAIL:  pos_next = POS_HUNT;
      // Header hunt; unused position codes behave the same way.
      default:   pos_next = (rx_byte == HDR_FIRST) ? POS_HDR2 : POS_HUNT;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    running_sum_next = running_sum;
    sum_matched_next = sum_matched;
    frame_done       = 1'b0;
    unique case (pos) inside
      POS_DATA0: running_sum_next = rx_byte;
      POS_DATA1, POS_DATA2, POS_DATA3, POS_DATA4, POS_DATA5:
        running_sum_next = running_sum + rx_byte;
      POS_SUM:   sum_matched_next = (running_sum == rx_byte);
      POS_TAIL:  frame_done = sum_matched;
      default: ;
    endcase
  end

  assign frame = '{done:     frame_done,
                   pm25_raw: {value_bytes[1], value_bytes[0]},
                   pm10_raw: {value_bytes[3], value_bytes[2]}};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HUNT;
      running_sum <= 8'd0;
      sum_matched <= 1'b0;
    end else if (rx_take) begin
      pos         <= pos_next;
      running_sum <= running_sum_next;
      sum_matched <= sum_matched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      case (pos)
        POS_DATA0: value_bytes[0] <= rx_byte;
        POS_DATA1: value_bytes[1] <= rx_byte;
        POS_DATA2: value_bytes[2] <= rx_byte;
        POS_DATA3: value_bytes[3] <= rx_byte;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/pmfd_classifier.sv */
// Saturation, level classification and floor flags for one frame.
`timescale 1ns / 1ps

module pmfd_classifier
  import pmfd_pkg::*;
(
  input  frame_t  frame,
  input  cfg_t    cfg,
  output result_t result
);

  logic [VAL_W-1:0] pm25_sat;
  logic [VAL_W-1:0] pm10_sat;

  function automatic logic [VAL_W-1:0] saturate(input logic [15:0] raw);
    logic [15:0] v;
    v = (raw > SAT_LIMIT) ? SAT_LIMIT : raw;
    return v[VAL_W-1:0];
  endfunction

  // Limits are tested in order; the first one not exceeded sets the level.
  function automatic level_t classify(input logic [VAL_W-1:0] v,
                                      input logic [VAL_W-1:0] good,
                                      input logic [VAL_W-1:0] moderate,
                                      input logic [VAL_W-1:0] degraded);
    level_t lvl;
    if (v <= good) begin
      lvl = LEVEL_GOOD;
    end else if (v <= moderate) begin
      lvl = LEVEL_MODERATE;
    end else if (v <= degraded) begin
      lvl = LEVEL_DEGRADED;
    end else begin
      lvl = LEVEL_BAD;
    end
    return lvl;
  endfunction

  assign pm25_sat = saturate(frame.pm25_raw);
  assign pm10_sat = saturate(frame.pm10_raw);

  assign result.pm25_tenths      = pm25_sat;
  assign result.pm10_tenths      = pm10_sat;
  assign result.pm25_level       = classify(pm25_sat, cfg.pm25_good_max,
                                            cfg.pm25_moderate_max, cfg.pm25_degraded_max);
  assign result.pm10_level       = classify(pm10_sat, cfg.pm10_good_max,
                                            cfg.pm10_moderate_max, cfg.pm10_degraded_max);
  assign result.pm25_below_floor = (pm25_sat < cfg.pm25_floor);
  assign result.pm10_below_floor = (pm10_sat < cfg.pm10_floor);

endmodule

/* rtl/pm_frame_decoder_classifier.sv */
// Top level of the particulate sensor frame decoder and classifier.
`timescale 1ns / 1ps

// Usage:
// The rx channel (rx_valid, rx_ready, rx_byte) carries one serial byte per
// word. The block hunts for the two-byte header, collects six payload bytes,
// checks their modulo-256 sum against the checksum byte and takes the tail
// byte unchecked. A good frame yields one word on the result channel
// (res_valid, res_ready and the six result fields); a bad frame yields none.
// Throughput is one byte per cycle while rx_ready is high, set by the frame
// position update in the parser. The result word appears in the cycle after
// the tail byte is accepted, taken from the result register that follows the
// classifier.
// When the receiver stalls, the result register holds its word and rx_ready
// stays low until that word is taken; in the cycle where it is taken rx_ready
// is high again, so a receiver that keeps up never stalls the byte stream.
// Reset (rst, synchronous, active high) returns the parser to header hunt,
// clears the pending result and loads the default level limits and floors.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
// clock edge; indexes beyond the register list are ignored.

module pm_frame_decoder_classifier
  import pmfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0] cfg_data,
  input  logic             rx_valid,
  output logic             rx_ready,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  input  logic             res_ready,
  output logic [VAL_W-1:0] pm25_tenths,
  output logic [VAL_W-1:0] pm10_tenths,
  output logic [1:0]       pm25_level,
  output logic [1:0]       pm10_level,
  output logic             pm25_below_floor,
  output logic             pm10_below_floor
);

  cfg_t    cfg;
  frame_t  frame;
  result_t result_comb;
  result_t result;
  logic    rx_take;

  // A new byte may enter whenever the result register is empty or draining.
  assign rx_ready = !res_valid || res_ready;
  assign rx_take  = rx_valid && rx_ready;

  pmfd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pmfd_frame_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .rx_take (rx_take),
    .rx_byte (rx_byte),
    .frame   (frame)
  );

  pmfd_classifier u_classifier (
    .frame  (frame),
    .cfg    (cfg),
    .result (result_comb)
  );

  // Result register: loaded when the tail byte of a good frame is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_take && frame.done) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take && frame.done) begin
      result <= result_comb;
    end
  end

  assign pm25_tenths      = result.pm25_tenths;
  assign pm10_tenths      = result.pm10_tenths;
  assign pm25_level       = result.pm25_level;
  assign pm10_level       = result.pm10_level;
  assign pm25_below_floor = result.pm25_below_floor;
  assign pm10_below_floor = result.pm10_below_floor;

endmodule
